// ===== design/dsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants of the depth slab projection
// Item layouts between front, job queue and back, register codes, limits.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int MAX_DEPTH   = 1024;
    localparam int SUM_W       = 18;
    localparam int COUNT_W     = 11;
    localparam int DIV_STEPS   = 26;   // (sum << 8) is 26 bits wide
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int JQ_DEPTH    = 2;
    localparam int OQ_DEPTH    = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_EXTEND   = 3'd1;
    localparam logic [2:0] CFG_TOP_OFS  = 3'd2;
    localparam logic [2:0] CFG_BOT_OFS  = 3'd3;
    localparam logic [2:0] CFG_COL_LEN  = 3'd4;

    typedef struct packed {
        logic              projection_mode;
        logic              extend_to_bottom;
        logic signed [6:0] top_offset;
        logic signed [6:0] bottom_offset;
        logic [10:0]       column_length;
    } cfg_t;

    // one finished column, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [7:0]         max;
        logic               mode;
    } job_t;

    typedef struct packed {
        logic [15:0] value;
        logic        empty;
    } res_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_PUSH
    } back_state_t;

endpackage

// ===== design/dsp_front.sv =====
// ----------------------------------------------------------------------------
// dsp_front: window test and column accumulation
// Tests each pixel against the slab window, keeps sum, count and maximum,
// and hands the totals to the job queue on the last pixel of a column.
// ----------------------------------------------------------------------------
module dsp_front
    import dsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        accept,
    input  logic [7:0]  pixel_value,
    input  logic [9:0]  depth_row,
    input  logic [9:0]  top_boundary,
    input  logic [9:0]  bottom_boundary,
    input  logic        last_in_column,
    output logic        job_push,
    output job_t        job
);

    logic [SUM_W-1:0]   sum_reg, sum_next, sum_acc;
    logic [COUNT_W-1:0] count_reg, count_next, count_acc;
    logic [7:0]         max_reg, max_next, max_acc;
    logic signed [11:0] start_s, end_s, row_s;
    logic               in_win;
    logic [SUM_W:0]     sum_wide;

    always_comb
    begin
        row_s = {2'b00, depth_row};
        if (cfg.extend_to_bottom)
        begin
            start_s = {2'b00, top_boundary};
            end_s   = (cfg.column_length > 11'(MAX_DEPTH)) ? 12'(MAX_DEPTH)
                                                            : {1'b0, cfg.column_length};
        end
        else
        begin
            start_s = $signed({2'b00, top_boundary})
                    + $signed({{5{cfg.top_offset[6]}}, cfg.top_offset});
            end_s   = $signed({2'b00, bottom_boundary})
                    + $signed({{5{cfg.bottom_offset[6]}}, cfg.bottom_offset});
        end
        in_win = (row_s >= start_s) && (row_s < end_s);

        // saturating accumulation
        sum_wide  = {1'b0, sum_reg} + {{(SUM_W-7){1'b0}}, pixel_value};
        sum_acc   = sum_reg;
        count_acc = count_reg;
        max_acc   = max_reg;
        if (in_win)
        begin
            sum_acc   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
            count_acc = (&count_reg) ? count_reg : count_reg + 1'b1;
            max_acc   = (pixel_value > max_reg) ? pixel_value : max_reg;
        end

        job.sum  = sum_acc;
        job.count = count_acc;
        job.max  = max_acc;
        job.mode = cfg.projection_mode;
        job_push = accept && last_in_column;

        sum_next   = sum_reg;
        count_next = count_reg;
        max_next   = max_reg;
        if (accept)
        begin
            sum_next   = last_in_column ? '0 : sum_acc;
            count_next = last_in_column ? '0 : count_acc;
            max_next   = last_in_column ? '0 : max_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            max_reg   <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            max_reg   <= max_next;
        end
    end

endmodule

// ===== design/dsp_job_queue.sv =====
// ----------------------------------------------------------------------------
// dsp_job_queue: short queue of finished columns
// Two-entry queue that lets the front keep streaming while the back divides.
// ----------------------------------------------------------------------------
module dsp_job_queue
    import dsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(JQ_DEPTH);

    job_t               mem [JQ_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_W:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == (PTR_W+1)'(JQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_reg];

    always_comb
    begin
        wr_next  = (push && !full) ? wr_reg + 1'b1 : wr_reg;
        rd_next  = (pop && !empty) ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule

// ===== design/dsp_back.sv =====
// ----------------------------------------------------------------------------
// dsp_back: per-column result unit
// Turns a column's totals into the 8.8 result: maximum by shift, mean by a
// radix-2 restoring divider (one quotient bit per cycle). Results wait in a
// two-entry output queue.
// ----------------------------------------------------------------------------
module dsp_back
    import dsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    input  logic        job_empty,
    output logic        job_pop,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] projection_value,
    output logic        window_empty
);

    localparam int PTR_W = $clog2(OQ_DEPTH);

    back_state_t            state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next, div_reg, div_next;
    logic [DIV_STEPS-1:0]   quo_reg, quo_next;
    res_t                   res_reg, res_next;
    logic [COUNT_W:0]       trial;
    logic                   q_bit;

    res_t                   oq_mem [OQ_DEPTH];
    logic [PTR_W-1:0]       owr_reg, owr_next, ord_reg, ord_next;
    logic [PTR_W:0]         ocnt_reg, ocnt_next;
    logic                   oq_full, oq_push, oq_pop;

    assign oq_full = (ocnt_reg == (PTR_W+1)'(OQ_DEPTH));
    assign empty   = (ocnt_reg == '0);
    assign oq_pop  = pop && !empty;
    assign projection_value = oq_mem[ord_reg].value;
    assign window_empty     = oq_mem[ord_reg].empty;

    // divider step: shift in the next dividend bit, subtract when it fits
    assign trial = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign q_bit = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;
        job_pop    = 1'b0;
        oq_push    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    state_next = BK_PUSH;
                    if (job.count == '0)
                    begin
                        res_next = '{value: 16'h0000, empty: 1'b1};
                    end
                    else if (job.mode)
                    begin
                        res_next = '{value: {job.max, 8'h00}, empty: 1'b0};
                    end
                    else if ({1'b0, job.sum} >= {job.count, 8'h00})
                    begin
                        // quotient would not fit 16 bits
                        res_next = '{value: 16'hFFFF, empty: 1'b0};
                    end
                    else
                    begin
                        rem_next   = '0;
                        div_next   = job.count;
                        quo_next   = {job.sum, 8'h00};
                        step_next  = '0;
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                rem_next  = q_bit ? COUNT_W'(trial - {1'b0, div_reg}) : trial[COUNT_W-1:0];
                quo_next  = {quo_reg[DIV_STEPS-2:0], q_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    res_next   = '{value: quo_next[15:0], empty: 1'b0};
                    state_next = BK_PUSH;
                end
            end
            BK_PUSH:
            begin
                if (!oq_full)
                begin
                    oq_push    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        owr_next  = oq_push ? owr_reg + 1'b1 : owr_reg;
        ord_next  = oq_pop ? ord_reg + 1'b1 : ord_reg;
        ocnt_next = ocnt_reg + (PTR_W+1)'(oq_push) - (PTR_W+1)'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
            owr_reg   <= '0;
            ord_reg   <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            owr_reg   <= owr_next;
            ord_reg   <= ord_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
        if (oq_push)
        begin
            oq_mem[owr_reg] <= res_reg;
        end
    end

endmodule

// ===== design/depth_slab_projection.sv =====
// ----------------------------------------------------------------------------
// depth_slab_projection: en-face slab projection of depth columns
// Mean or maximum of the pixels of each column inside a layer-bounded window.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive one pixel item (value, row, the column's top and bottom
//   boundaries, last-in-column mark) and raise push; it is taken on a clock
//   edge with push high and full low. Pixels stream at one item per cycle while full is low.
//   Result queue: while empty is low the oldest result (8.8 value plus the
//   empty-window flag) sits on the result ports; pop takes it.
//   One result per column, produced after its last pixel.
// Result path:
//   Mean mode: the column's totals go through the column queue into the
//   one-bit-per-cycle divider (26 steps), then into the result queue.
//   Maximum mode, empty window or quotient overflow: the divider is skipped.
//   The back end takes no new column until the last one is in the result queue;
//   a two-entry column queue and a two-entry result queue absorb short
//   columns, after which full rises until the divider catches up.
// Reset: clears accumulators, queues and configuration registers (column length 1024).
// Receiver stall: results pile up in the output queue, then the back end
//   waits, the column queue fills and full holds off new pixels.
// Configuration: write only while no item is in flight.
// ----------------------------------------------------------------------------
module depth_slab_projection
    import dsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    // pixel items
    input  logic        push,
    output logic        full,
    input  logic [7:0]  pixel_value,
    input  logic [9:0]  depth_row,
    input  logic [9:0]  top_boundary,
    input  logic [9:0]  bottom_boundary,
    input  logic        last_in_column,
    // result items
    output logic        empty,
    input  logic        pop,
    output logic [15:0] projection_value,
    output logic        window_empty
);

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic jq_push, jq_pop, jq_full, jq_empty;
    job_t jq_in, jq_head;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:    cfg_next.projection_mode  = cfg_data[0];
                CFG_EXTEND:  cfg_next.extend_to_bottom = cfg_data[0];
                CFG_TOP_OFS: cfg_next.top_offset       = cfg_data[6:0];
                CFG_BOT_OFS: cfg_next.bottom_offset    = cfg_data[6:0];
                CFG_COL_LEN: cfg_next.column_length    = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{projection_mode: 1'b0, extend_to_bottom: 1'b0,
                         top_offset: 7'sd0, bottom_offset: 7'sd0,
                         column_length: 11'(MAX_DEPTH)};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // the front stalls only when there is no room for a finished column
    assign full   = jq_full;
    assign accept = push && !full;

    dsp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .accept          (accept),
        .pixel_value     (pixel_value),
        .depth_row       (depth_row),
        .top_boundary    (top_boundary),
        .bottom_boundary (bottom_boundary),
        .last_in_column  (last_in_column),
        .job_push        (jq_push),
        .job             (jq_in)
    );

    dsp_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (jq_push),
        .push_job (jq_in),
        .pop      (jq_pop),
        .head     (jq_head),
        .full     (jq_full),
        .empty    (jq_empty)
    );

    dsp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job              (jq_head),
        .job_empty        (jq_empty),
        .job_pop          (jq_pop),
        .pop              (pop),
        .empty            (empty),
        .projection_value (projection_value),
        .window_empty     (window_empty)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        jq_push |-> !jq_full)
        else $error("column pushed into full job queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        jq_pop |-> !jq_empty)
        else $error("back end popped an empty job queue");

    a_empty_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && window_empty) |-> (projection_value == 16'h0000))
        else $error("empty window with nonzero value");
`endif

endmodule
